// ----- rtl/core/brc_pkg.sv -----
// Package with shared types and constants of the block reassembly collector.
package brc_pkg;

    localparam int MAX_BLOCKS_DEF   = 8;
    localparam int MAX_SUBBANDS_DEF = 16;

    localparam logic [1:0] KIND_BLOCK = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_LATE  = 2'd2;
    localparam logic [1:0] KIND_FULL  = 2'd3;

    localparam logic CFG_MAX_IN_FLIGHT = 1'b0;
    localparam logic CFG_SUBBAND_COUNT = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE    = 4'd0,
        OP_LOOKUP  = 4'd1,
        OP_APPLY   = 4'd2,
        OP_SCAN    = 4'd3,
        OP_EMIT    = 4'd4,
        OP_NOTE    = 4'd5
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic       emit_limit;
        logic [1:0] note_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic found;
        logic late;
        logic full;
        logic can_drop;
        logic complete;
        logic any_open;
        logic low_le_blk;
    } dp_status_t;

endpackage

// ----- rtl/core/brc_datapath.sv -----
// Datapath of the block reassembly collector: open table, scans and result register.
module brc_datapath #(
    parameter int MAX_BLOCKS   = brc_pkg::MAX_BLOCKS_DEF,
    parameter int MAX_SUBBANDS = brc_pkg::MAX_SUBBANDS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic                cfg_idx,
    input  logic [4:0]          cfg_data,
    input  logic                in_load,
    input  logic                in_mode,
    input  logic [31:0]         in_block,
    input  logic [3:0]          in_subband,
    input  brc_pkg::dp_cmd_t    cmd,
    output brc_pkg::dp_status_t status,
    output logic                in_mode_q,
    output logic [1:0]          res_kind,
    output logic [31:0]         res_block,
    output logic [15:0]         res_mask
);
    import brc_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int IWS = (MAX_SUBBANDS > 1) ? $clog2(MAX_SUBBANDS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int RW = $clog2(MAX_SUBBANDS + 1);

    logic [3:0]        mif_reg;
    logic [4:0]        sbc_reg;
    logic              mode_reg;
    logic [31:0]       blk_reg;
    logic [3:0]        sb_reg;

    logic [MAX_BLOCKS-1:0] valid_reg;
    logic [31:0]           eblk_reg [MAX_BLOCKS];
    logic [MAX_SUBBANDS-1:0] emask_reg [MAX_BLOCKS];
    logic [RW-1:0]         erem_reg [MAX_BLOCKS];
    logic                  any_reg;
    logic [31:0]           lastb_reg;

    logic              found_reg;
    logic [IW-1:0]     slot_reg;
    logic              low_ok_reg;
    logic [IW-1:0]     low_reg;

    logic [1:0]        kind_reg;
    logic [31:0]       rblk_reg;
    logic [15:0]       rmask_reg;

    logic          hit;
    logic [IW-1:0] hit_idx;
    logic          free_ok;
    logic [IW-1:0] free_idx;
    logic [CW-1:0] cnt;
    logic          low_ok;
    logic [IW-1:0] low_idx;
    logic [CW-1:0] limit;
    logic [RW-1:0] due;
    logic [IWS-1:0] sb_idx;

    assign sb_idx = IWS'(sb_reg);

    always_comb begin
        hit = 1'b0;
        hit_idx = '0;
        free_ok = 1'b0;
        free_idx = '0;
        cnt = '0;
        low_ok = 1'b0;
        low_idx = '0;
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (valid_reg[i] && eblk_reg[i] == blk_reg) begin
                hit = 1'b1;
                hit_idx = IW'(i);
            end
            if (!valid_reg[i] && !free_ok) begin
                free_ok = 1'b1;
                free_idx = IW'(i);
            end
            if (valid_reg[i]) begin
                cnt = cnt + CW'(1);
            end
        end
        // Lowest open block, ties to the lowest slot.
        for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (valid_reg[i] && (!low_ok || eblk_reg[i] < eblk_reg[low_idx])) begin
                low_ok = 1'b1;
                low_idx = IW'(i);
            end
        end
        if (mif_reg == 4'd0 || 32'(mif_reg) > 32'(MAX_BLOCKS)) begin
            limit = CW'(MAX_BLOCKS);
        end else begin
            limit = CW'(mif_reg);
        end
        if (sbc_reg == 5'd0) begin
            due = RW'(1);
        end else if (32'(sbc_reg) > 32'(MAX_SUBBANDS)) begin
            due = RW'(MAX_SUBBANDS);
        end else begin
            due = RW'(sbc_reg);
        end
    end

    assign status.found      = found_reg;
    assign status.late       = any_reg && blk_reg <= lastb_reg;
    assign status.full       = cnt >= limit;
    assign status.can_drop   = mif_reg != 4'd0;
    assign status.complete   = erem_reg[slot_reg] == '0;
    assign status.any_open   = low_ok_reg;
    assign status.low_le_blk = eblk_reg[low_reg] <= blk_reg;

    assign in_mode_q = mode_reg;
    assign res_kind  = kind_reg;
    assign res_block = rblk_reg;
    assign res_mask  = rmask_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mif_reg    <= '0;
            sbc_reg    <= 5'd16;
            valid_reg  <= '0;
            any_reg    <= 1'b0;
            lastb_reg  <= '0;
            found_reg  <= 1'b0;
            low_ok_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_idx)
                    CFG_MAX_IN_FLIGHT: mif_reg <= cfg_data[3:0];
                    CFG_SUBBAND_COUNT: sbc_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (cmd.op)
                OP_LOOKUP: begin
                    found_reg <= hit;
                    slot_reg  <= hit ? hit_idx : free_idx;
                end
                OP_APPLY: begin
                    if (!found_reg) begin
                        valid_reg[slot_reg] <= 1'b1;
                        eblk_reg[slot_reg]  <= blk_reg;
                    end
                    if (32'(sb_reg) < 32'(MAX_SUBBANDS)) begin
                        if (found_reg) begin
                            if (!emask_reg[slot_reg][sb_idx] &&
                                erem_reg[slot_reg] != '0) begin
                                emask_reg[slot_reg][sb_idx] <= 1'b1;
                                erem_reg[slot_reg] <= erem_reg[slot_reg] - RW'(1);
                            end
                        end else begin
                            emask_reg[slot_reg] <= MAX_SUBBANDS'(1) << sb_reg;
                            erem_reg[slot_reg]  <= due - RW'(1);
                        end
                    end else if (!found_reg) begin
                        emask_reg[slot_reg] <= '0;
                        erem_reg[slot_reg]  <= due;
                    end
                end
                OP_SCAN: begin
                    low_ok_reg <= low_ok;
                    low_reg    <= low_idx;
                end
                OP_EMIT: begin
                    valid_reg[low_reg] <= 1'b0;
                    any_reg   <= 1'b1;
                    lastb_reg <= eblk_reg[low_reg];
                    kind_reg  <= KIND_BLOCK;
                    rblk_reg  <= eblk_reg[low_reg];
                    rmask_reg <= 16'(emask_reg[low_reg]);
                    if (cmd.emit_limit) begin
                        // Eviction frees the slot that the new block will take.
                        slot_reg <= low_reg;
                    end
                end
                OP_NOTE: begin
                    kind_reg  <= cmd.note_kind;
                    rblk_reg  <= '0;
                    rmask_reg <= '0;
                end
                default: ;
            endcase
        end
        if (in_load) begin
            mode_reg <= in_mode;
            blk_reg  <= in_block;
            sb_reg   <= in_subband;
        end
    end

endmodule

// ----- rtl/core/brc_ctrl.sv -----
// Controller state machine of the block reassembly collector.
module brc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                in_load,
    input  logic                in_mode_q,
    input  brc_pkg::dp_status_t status,
    output brc_pkg::dp_cmd_t    cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_last
);
    import brc_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LOOKUP = 10'b0000000010,
        S_DECIDE = 10'b0000000100,
        S_EVSCAN = 10'b0000001000,
        S_EVICT  = 10'b0000010000,
        S_APPLY  = 10'b0000100000,
        S_SCAN   = 10'b0001000000,
        S_CHECK  = 10'b0010000000,
        S_OUT    = 10'b0100000000,
        S_NOTE   = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    logic   flush_reg, flush_next;
    logic   pend_reg, pend_next;
    logic   mv_reg, mv_next;
    logic   ml_reg, ml_next;
    logic   out_free;

    assign s_ready  = aresetn && state_reg == S_IDLE;
    assign in_load  = s_valid && s_ready;
    assign m_valid  = mv_reg;
    assign m_last   = ml_reg;
    assign out_free = !mv_reg || m_ready;

    // An emitted block waits in the result register until it is known whether another
    // word follows; only then is it presented with its final last flag.
    always_comb begin
        state_next = state_reg;
        flush_next = flush_reg;
        pend_next  = pend_reg;
        mv_next    = mv_reg && !m_ready;
        ml_next    = ml_reg;
        cmd        = '{op: OP_NONE, emit_limit: 1'b0, note_kind: KIND_END};
        case (state_reg)
            S_IDLE: begin
                if (in_load) begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP: begin
                if (in_mode_q) begin
                    flush_next = 1'b1;
                    cmd.op = OP_SCAN;
                    state_next = S_CHECK;
                end else begin
                    flush_next = 1'b0;
                    cmd.op = OP_LOOKUP;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (status.found) begin
                    state_next = S_APPLY;
                end else if (status.late) begin
                    if (status.can_drop) begin
                        state_next = S_IDLE;
                    end else begin
                        state_next = S_NOTE;
                    end
                end else if (status.full) begin
                    if (status.can_drop) begin
                        cmd.op = OP_SCAN;
                        state_next = S_EVSCAN;
                    end else begin
                        state_next = S_NOTE;
                    end
                end else begin
                    state_next = S_APPLY;
                end
            end
            S_NOTE: begin
                if (out_free) begin
                    cmd.op = OP_NOTE;
                    if (flush_reg) begin
                        cmd.note_kind = KIND_END;
                    end else if (status.late) begin
                        cmd.note_kind = KIND_LATE;
                    end else begin
                        cmd.note_kind = KIND_FULL;
                    end
                    mv_next = 1'b1;
                    ml_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EVSCAN: begin
                state_next = S_EVICT;
            end
            S_EVICT: begin
                if (out_free) begin
                    cmd.op = OP_EMIT;
                    cmd.emit_limit = 1'b1;
                    pend_next = 1'b1;
                    state_next = S_APPLY;
                end
            end
            S_APPLY: begin
                cmd.op = OP_APPLY;
                state_next = S_SCAN;
            end
            S_SCAN: begin
                if (flush_reg || status.complete) begin
                    cmd.op = OP_SCAN;
                    state_next = S_CHECK;
                end else begin
                    if (pend_reg) begin
                        mv_next = 1'b1;
                        ml_next = 1'b1;
                        pend_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_CHECK: begin
                if (status.any_open && (flush_reg || status.low_le_blk)) begin
                    if (pend_reg) begin
                        mv_next = 1'b1;
                        ml_next = 1'b0;
                        pend_next = 1'b0;
                    end
                    state_next = S_OUT;
                end else if (flush_reg) begin
                    if (pend_reg) begin
                        mv_next = 1'b1;
                        ml_next = 1'b0;
                        pend_next = 1'b0;
                    end
                    state_next = S_NOTE;
                end else begin
                    if (pend_reg) begin
                        mv_next = 1'b1;
                        ml_next = 1'b1;
                        pend_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.op = OP_EMIT;
                    pend_next = 1'b1;
                    state_next = S_SCAN;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            flush_reg <= 1'b0;
            pend_reg  <= 1'b0;
            mv_reg    <= 1'b0;
            ml_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            flush_reg <= flush_next;
            pend_reg  <= pend_next;
            mv_reg    <= mv_next;
            ml_reg    <= ml_next;
        end
    end

endmodule

// ----- rtl/core/block_reassembly_collector_top.sv -----
// Top level of the block reassembly collector.
// Input words on s_* carry a subband arrival (s_mode 0) or a finish request (s_mode 1).
// Result words on m_* carry emitted blocks, the end marker or an error; m_last marks
// the final word caused by one input word. An input that causes no result gives none.
// The user writes configuration through cfg_we, cfg_index and cfg_data only while
// the block idles; the block itself does not enforce this. One input word is handled
// at a time; s_ready is high only while the controller waits. A finish request gives
// the words of all open blocks and then the end marker.
// Each emission is a search for the lowest open block followed by a pop into the
// output register, which is presented once its last flag is known.
// When the receiver stalls, the controller waits before the next emission until the
// output register is free; a held word keeps its payload.
// Reset empties the open table, clears the last emitted index and returns the
// configuration registers to their defaults.
module block_reassembly_collector_top #(
    parameter int MAX_BLOCKS   = brc_pkg::MAX_BLOCKS_DEF,
    parameter int MAX_SUBBANDS = brc_pkg::MAX_SUBBANDS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [31:0] s_block_index,
    input  logic [3:0]  s_subband_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_emitted_block,
    output logic [15:0] m_received_mask,
    output logic        m_last
);
    import brc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_load;
    logic       in_mode_q;

    brc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .in_load(in_load),
        .in_mode_q(in_mode_q), .status(status), .cmd(cmd),
        .m_valid(m_valid), .m_ready(m_ready), .m_last(m_last)
    );

    brc_datapath #(.MAX_BLOCKS(MAX_BLOCKS), .MAX_SUBBANDS(MAX_SUBBANDS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_idx(cfg_index), .cfg_data(cfg_data),
        .in_load(in_load), .in_mode(s_mode), .in_block(s_block_index),
        .in_subband(s_subband_index), .cmd(cmd), .status(status),
        .in_mode_q(in_mode_q), .res_kind(m_kind), .res_block(m_emitted_block),
        .res_mask(m_received_mask)
    );

endmodule
